// ----- sv/binary_subarray_sum_counter_top_assert.svh -----
// Assertion macros for the subarray sum counter.
// Both expect clk and rst_n in scope.
`ifndef BINARY_SUBARRAY_SUM_COUNTER_TOP_ASSERT_SVH
`define BINARY_SUBARRAY_SUM_COUNTER_TOP_ASSERT_SVH

// cond holds at every edge out of reset
`define BSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the cycle after ante
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bsc_pkg.sv -----
`default_nettype none

package bsc_pkg;

  localparam int GOAL_W = 11;
  localparam int CNT_W  = 20;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // word index within the register space (paddr[2])
  localparam logic REG_GOAL = 1'b0;

  typedef struct packed {
    logic accept;     // take the input transaction
    logic shrink_u;   // drop the leftmost bit of the upper window
    logic add_u;      // add upper window length to its count
    logic shrink_l;   // drop the leftmost bit of the lower window
    logic add_l;      // add lower window length to its count
    logic sel_lower;  // history read port follows the lower window
    logic load_out;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic full;       // history holds MAX_LEN items
    logic need_u;     // upper window still over its limit
    logic need_l;     // lower window still over its limit
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/bsc_in_if.sv -----
`default_nettype none

interface bsc_in_if;
  logic valid;
  logic ready;
  logic bit_req;
  logic last;

  modport source (output valid, output bit_req, output last, input ready);
  modport sink (input valid, input bit_req, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/bsc_out_if.sv -----
`default_nettype none

interface bsc_out_if;
  import bsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] total;
  logic             done_res;
  logic             overflow;

  modport source (output valid, output total, output done_res, output overflow, input ready);
  modport sink (input valid, input total, input done_res, input overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/bsc_ram.sv -----
`default_nettype none

module bsc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/bsc_ctrl.sv -----
`default_nettype none

module bsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsc_pkg::sts_t sts,
  output bsc_pkg::cmd_t cmd
);
  import bsc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPPER,
    ST_LOWER,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.full ? ST_FINISH : ST_UPPER;
        end
      end
      ST_UPPER: begin
        if (sts.need_u) begin
          cmd.shrink_u = 1'b1;
        end else begin
          // hand the read port over to the lower window
          cmd.add_u     = 1'b1;
          cmd.sel_lower = 1'b1;
          state_nxt     = ST_LOWER;
        end
      end
      ST_LOWER: begin
        cmd.sel_lower = 1'b1;
        if (sts.need_l) begin
          cmd.shrink_l = 1'b1;
        end else if (sts.out_free) begin
          cmd.add_l    = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_ready_nxt = (state_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

// ----- sv/bsc_datapath.sv -----
`default_nettype none

module bsc_datapath #(
  parameter int MAX_LEN = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bsc_pkg::cmd_t               cmd,
  output bsc_pkg::sts_t               sts,
  input  logic [bsc_pkg::GOAL_W-1:0]  goal,
  input  logic                        in_bit,
  input  logic                        in_last,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [bsc_pkg::CNT_W-1:0]   out_total,
  output logic                        out_done,
  output logic                        out_ovf
);
  import bsc_pkg::*;

  localparam int PW    = $clog2(MAX_LEN + 1);
  localparam int AW    = $clog2(MAX_LEN);
  localparam int CMP_W = (PW > GOAL_W) ? PW : GOAL_W;

  logic [PW-1:0]    pos_r, pos_nxt;
  logic [PW-1:0]    left_u_r, left_u_nxt;
  logic [PW-1:0]    left_l_r, left_l_nxt;
  logic [PW-1:0]    sum_u_r, sum_u_nxt;
  logic [PW-1:0]    sum_l_r, sum_l_nxt;
  logic [CNT_W-1:0] cnt_u_r, cnt_u_nxt;
  logic [CNT_W-1:0] cnt_l_r, cnt_l_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             bit_r, bit_nxt;
  logic             last_r, last_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] out_total_r, out_total_nxt;
  logic             out_done_r, out_done_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             full;
  logic             lower_on;
  logic [CNT_W-1:0] len_u, len_l, cnt_l_upd;
  logic             rbit_u, rbit_l;

  logic             mem_we;
  logic [AW-1:0]    mem_raddr;
  logic             mem_rdata;

  bsc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LEN)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (in_bit),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign full     = (pos_r == PW'(MAX_LEN));
  assign lower_on = (goal != '0);
  assign len_u    = CNT_W'(pos_r - left_u_r);
  assign len_l    = CNT_W'(pos_r - left_l_r);
  assign cnt_l_upd = cnt_l_r + ((cmd.add_l && lower_on) ? len_l : '0);

  // newest entry may have been written in the same cycle it was read: bypass it
  assign rbit_u = ((left_u_r + PW'(1)) == pos_r) ? bit_r : mem_rdata;
  assign rbit_l = ((left_l_r + PW'(1)) == pos_r) ? bit_r : mem_rdata;

  assign sts.full     = full;
  assign sts.need_u   = (CMP_W'(sum_u_r) > CMP_W'(goal)) && (left_u_r < pos_r);
  assign sts.need_l   = lower_on && (CMP_W'(sum_l_r) >= CMP_W'(goal)) &&
                        (left_l_r < pos_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign mem_we = cmd.accept && !full;

  always_comb begin
    pos_nxt       = pos_r;
    left_u_nxt    = left_u_r;
    left_l_nxt    = left_l_r;
    sum_u_nxt     = sum_u_r;
    sum_l_nxt     = sum_l_r;
    cnt_u_nxt     = cnt_u_r;
    cnt_l_nxt     = cnt_l_r;
    bit_nxt       = bit_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    out_total_nxt = out_total_r;
    out_done_nxt  = out_done_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.accept) begin
      last_nxt = in_last;
      ovf_nxt  = full;
      if (!full) begin
        bit_nxt   = in_bit;
        pos_nxt   = pos_r + PW'(1);
        sum_u_nxt = sum_u_r + PW'(in_bit);
        if (lower_on) begin
          sum_l_nxt = sum_l_r + PW'(in_bit);
        end
      end
    end

    if (cmd.shrink_u) begin
      sum_u_nxt  = sum_u_r - PW'(rbit_u);
      left_u_nxt = left_u_r + PW'(1);
    end
    if (cmd.add_u) begin
      cnt_u_nxt = cnt_u_r + len_u;
    end

    if (cmd.shrink_l) begin
      sum_l_nxt  = sum_l_r - PW'(rbit_l);
      left_l_nxt = left_l_r + PW'(1);
    end
    if (cmd.add_l) begin
      cnt_l_nxt = cnt_l_upd;
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_total_nxt = cnt_u_r - cnt_l_upd;
      out_done_nxt  = last_r;
      out_ovf_nxt   = ovf_r;
      if (last_r) begin
        pos_nxt    = '0;
        left_u_nxt = '0;
        left_l_nxt = '0;
        sum_u_nxt  = '0;
        sum_l_nxt  = '0;
        cnt_u_nxt  = '0;
        cnt_l_nxt  = '0;
      end
    end
  end

  assign mem_raddr = cmd.sel_lower ? left_l_nxt[AW-1:0] : left_u_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      left_u_r    <= '0;
      left_l_r    <= '0;
      sum_u_r     <= '0;
      sum_l_r     <= '0;
      cnt_u_r     <= '0;
      cnt_l_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      left_u_r    <= left_u_nxt;
      left_l_r    <= left_l_nxt;
      sum_u_r     <= sum_u_nxt;
      sum_l_r     <= sum_l_nxt;
      cnt_u_r     <= cnt_u_nxt;
      cnt_l_r     <= cnt_l_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r       <= bit_nxt;
    last_r      <= last_nxt;
    ovf_r       <= ovf_nxt;
    out_total_r <= out_total_nxt;
    out_done_r  <= out_done_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;
  assign out_done  = out_done_r;
  assign out_ovf   = out_ovf_r;

endmodule

`default_nettype wire

// ----- sv/binary_subarray_sum_counter_top.sv -----
`default_nettype none
`include "binary_subarray_sum_counter_top_assert.svh"

// Counts contiguous runs of a bit stream whose number of ones equals the goal
// register. Each input transaction carries one bit and a last marker and
// yields exactly one result transaction: the running count (mod 2^20), the
// echoed last marker and an overflow flag. A sequence holds at most MAX_LEN
// bits; later bits are ignored and flagged until the last marker, which
// always ends the sequence and clears the counts (goal is kept). A stored bit
// is accepted; the upper, then the lower window drop bits from their left
// edge until back within limit, each at most one per bit it took in; then
// the result is posted once the result register is free. An ignored bit goes
// from accept straight to posting. The window steps share the single read
// port of the history RAM. The next input waits until the result is posted,
// not until it leaves the output side. Write goal only while idle.
module binary_subarray_sum_counter_top #(
  parameter int MAX_LEN = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bsc_in_if.sink                        in_ch,
  bsc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsc_pkg::APB_AW-1:0]    paddr,
  input  logic [bsc_pkg::APB_DW-1:0]    pwdata,
  output logic [bsc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import bsc_pkg::*;

  // goal register, APB word 0
  logic [GOAL_W-1:0] goal_r;
  logic              cfg_wr;

  cmd_t cmd_w;
  sts_t sts_w;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r <= '0;
    end else if (cfg_wr && (paddr[2] == REG_GOAL)) begin
      goal_r <= pwdata[GOAL_W-1:0];
    end
  end

  // reads of the unused word return zero
  assign prdata = (paddr[2] == REG_GOAL) ? APB_DW'(goal_r) : '0;

  // sequencer: accept, walk upper window, walk lower window, post result; ignored bits go straight to posting
  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts_w),
    .cmd      (cmd_w)
  );

  // history RAM, window edges and sums, counts, result register
  bsc_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_w),
    .sts       (sts_w),
    .goal      (goal_r),
    .in_bit    (in_ch.bit_req),
    .in_last   (in_ch.last),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_total (out_ch.total),
    .out_done  (out_ch.done_res),
    .out_ovf   (out_ch.overflow)
  );

  // one RAM port and one datapath action per cycle
  `BSC_ASSERT_ALWAYS(a_one_action, $onehot0({cmd_w.accept, cmd_w.shrink_u, cmd_w.shrink_l, cmd_w.load_out}), "more than one datapath action in a cycle")
  // a result is only posted into a free slot
  `BSC_ASSERT_ALWAYS(a_load_into_free, !cmd_w.load_out || sts_w.out_free, "result loaded over a pending result")
  // accepting a transaction makes the block busy
  `BSC_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input still ready right after an accept")
  // a posted result shows up on the output channel
  `BSC_ASSERT_NEXT(a_load_shows, cmd_w.load_out, out_ch.valid, "posted result not visible")

endmodule

`default_nettype wire
